[rtl/ots_pkg.sv]
`timescale 1ns / 1ps
package ots_pkg;

  localparam int TIME_W  = 32;
  localparam int TOUR_W  = 14;
  localparam int DOCK_W  = 8;
  localparam int RCNT_W  = 4;
  localparam int CFG_W   = 8;
  localparam int CFG_IW  = 1;

  localparam logic [TOUR_W-1:0] TOUR_MAX = {TOUR_W{1'b1}};
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam logic [CFG_IW-1:0] CFG_DOCK_TIME   = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_ROBOT_COUNT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_LEG,
    ST_CMP,
    ST_NEXT,
    ST_SCAN,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic accept;
    logic init;
    logic leg;
    logic cmp;
    logic next;
    logic scan;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic leg_last;
    logic heap_done;
    logic heap_swap;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

[rtl/ots_if.sv]
`timescale 1ns / 1ps
interface ots_in_if #(
  parameter int COORD_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic                  new_batch;
  logic [COORD_BITS-1:0] cell_x;
  logic [COORD_BITS-1:0] cell_y;
  logic                  last_cell;

  modport source (output valid, new_batch, cell_x, cell_y, last_cell, input ready);
  modport sink   (input valid, new_batch, cell_x, cell_y, last_cell, output ready);
endinterface

interface ots_out_if;
  import ots_pkg::*;
  logic              valid;
  logic              ready;
  logic [TOUR_W-1:0] tour_time;
  logic [TIME_W-1:0] start_time;
  logic [TIME_W-1:0] end_time;
  logic [TIME_W-1:0] makespan;
  logic              cells_dropped;

  modport source (output valid, tour_time, start_time, end_time, makespan,
                  cells_dropped, input ready);
  modport sink   (input valid, tour_time, start_time, end_time, makespan,
                  cells_dropped, output ready);
endinterface

[rtl/ots_ctrl.sv]
`timescale 1ns / 1ps
module ots_ctrl
  import ots_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_last_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_last_i) state_d = ST_INIT;
      end
      ST_INIT: state_d = ST_LEG;
      ST_LEG: begin
        if (sts_i.leg_last) state_d = ST_CMP;
      end
      ST_CMP: state_d = ST_NEXT;
      ST_NEXT: begin
        if (sts_i.heap_done) state_d = ST_SCAN;
        else if (sts_i.heap_swap) state_d = ST_LEG;
      end
      ST_SCAN: begin
        if (sts_i.scan_last) state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_INIT:   cmd_o.init = 1'b1;
      ST_LEG:    cmd_o.leg = 1'b1;
      ST_CMP:    cmd_o.cmp = 1'b1;
      ST_NEXT:   cmd_o.next = 1'b1;
      ST_SCAN:   cmd_o.scan = 1'b1;
      ST_COMMIT: cmd_o.commit = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

[rtl/ots_dp.sv]
`timescale 1ns / 1ps
module ots_dp
  import ots_pkg::*;
#(
  parameter int MAX_CELLS  = 5,
  parameter int MAX_ROBOTS = 8,
  parameter int COORD_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IW-1:0]     cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  new_batch_i,
  input  logic [COORD_BITS-1:0] cell_x_i,
  input  logic [COORD_BITS-1:0] cell_y_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [TOUR_W-1:0]     tour_time_o,
  output logic [TIME_W-1:0]     start_time_o,
  output logic [TIME_W-1:0]     end_time_o,
  output logic [TIME_W-1:0]     makespan_o,
  output logic                  cells_dropped_o,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o
);

  localparam int IW    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int CW    = $clog2(MAX_CELLS + 1);
  localparam int RW    = (MAX_ROBOTS > 1) ? $clog2(MAX_ROBOTS) : 1;
  localparam int JW    = $clog2(MAX_ROBOTS + 1);
  localparam int BASEW = ((COORD_BITS + 1 > DOCK_W) ? COORD_BITS + 1 : DOCK_W) + 4;
  localparam int ACC_W = (BASEW > TOUR_W + 1) ? BASEW : TOUR_W + 1;

  logic [DOCK_W-1:0]     dock_q;
  logic [RCNT_W-1:0]     rcnt_q;

  logic [COORD_BITS-1:0] sx_q [MAX_CELLS];
  logic [COORD_BITS-1:0] sy_q [MAX_CELLS];
  logic [CW-1:0]         cnt_q;
  logic                  ovf_q;

  logic [IW-1:0]         perm_q [MAX_CELLS];
  logic [IW-1:0]         hc_q   [MAX_CELLS];
  logic [CW-1:0]         hi_q;
  logic [CW-1:0]         pos_q;
  logic [COORD_BITS-1:0] px_q, py_q;
  logic [ACC_W-1:0]      acc_q, best_q;

  logic [TIME_W-1:0]     rft_q [MAX_ROBOTS];
  logic [TIME_W-1:0]     mk_q;
  logic [TIME_W-1:0]     bestf_q;
  logic [RW-1:0]         pick_q;
  logic [JW-1:0]         j_q;

  logic                  out_valid_q;
  logic [TOUR_W-1:0]     tour_q;
  logic [TIME_W-1:0]     start_q, finish_q, mko_q;
  logic                  drop_q;

  logic [IW-1:0]         cur;
  logic [COORD_BITS-1:0] cx, cy, dx, dy;
  logic [ACC_W-1:0]      leg, ret;
  logic [IW-1:0]         hidx, sw;
  logic                  hlt;
  logic [JW-1:0]         robots;
  logic [TOUR_W-1:0]     tour;
  logic [TIME_W:0]       fsum;
  logic [TIME_W-1:0]     finish;

  assign cur  = perm_q[pos_q[IW-1:0]];
  assign cx   = sx_q[cur];
  assign cy   = sy_q[cur];
  assign dx   = (px_q > cx) ? px_q - cx : cx - px_q;
  assign dy   = (py_q > cy) ? py_q - cy : cy - py_q;
  assign leg  = ACC_W'(dx) + ACC_W'(dy) + ACC_W'(dock_q);
  assign ret  = ACC_W'(px_q) + ACC_W'(py_q) + ACC_W'(dock_q);

  assign hidx = hi_q[IW-1:0];
  assign hlt  = CW'(hc_q[hidx]) < hi_q;
  assign sw   = hi_q[0] ? hc_q[hidx] : '0;

  always_comb begin
    if (rcnt_q == '0) robots = JW'(1);
    else if (32'(rcnt_q) > MAX_ROBOTS) robots = JW'(MAX_ROBOTS);
    else robots = JW'(rcnt_q);
  end

  assign tour   = (best_q >= ACC_W'(TOUR_MAX)) ? TOUR_MAX : best_q[TOUR_W-1:0];
  assign fsum   = {1'b0, bestf_q} + (TIME_W + 1)'(tour);
  assign finish = fsum[TIME_W] ? TIME_MAX : fsum[TIME_W-1:0];

  assign sts_o.leg_last  = (pos_q == cnt_q);
  assign sts_o.heap_done = (hi_q >= cnt_q);
  assign sts_o.heap_swap = hlt;
  assign sts_o.scan_last = (j_q >= robots);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dock_q <= '0;
      rcnt_q <= RCNT_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DOCK_TIME:   dock_q <= cfg_wdata_i[DOCK_W-1:0];
        CFG_ROBOT_COUNT: rcnt_q <= cfg_wdata_i[RCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && (cnt_q < CW'(MAX_CELLS))) begin
      sx_q[cnt_q[IW-1:0]] <= cell_x_i;
      sy_q[cnt_q[IW-1:0]] <= cell_y_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
      mk_q  <= '0;
      for (int r = 0; r < MAX_ROBOTS; r++) rft_q[r] <= '0;
    end else if (cmd_i.accept) begin
      if (new_batch_i) begin
        mk_q <= '0;
        for (int r = 0; r < MAX_ROBOTS; r++) rft_q[r] <= '0;
      end
      if (cnt_q < CW'(MAX_CELLS)) cnt_q <= cnt_q + CW'(1);
      else ovf_q <= 1'b1;
    end else if (cmd_i.commit) begin
      rft_q[pick_q] <= finish;
      if (finish > mk_q) mk_q <= finish;
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      for (int k = 0; k < MAX_CELLS; k++) begin
        perm_q[k] <= IW'(k);
        hc_q[k]   <= '0;
      end
      hi_q   <= CW'(1);
      pos_q  <= '0;
      acc_q  <= '0;
      px_q   <= '0;
      py_q   <= '0;
      best_q <= '1;
    end else if (cmd_i.leg) begin
      if (pos_q == cnt_q) begin
        acc_q <= acc_q + ret;
      end else begin
        acc_q <= acc_q + leg;
        px_q  <= cx;
        py_q  <= cy;
        pos_q <= pos_q + CW'(1);
      end
    end else if (cmd_i.cmp) begin
      if (acc_q < best_q) best_q <= acc_q;
    end else if (cmd_i.next) begin
      if (hi_q >= cnt_q) begin
        pick_q  <= '0;
        bestf_q <= rft_q[0];
        j_q     <= JW'(1);
      end else if (hlt) begin
        perm_q[sw]   <= perm_q[hidx];
        perm_q[hidx] <= perm_q[sw];
        hc_q[hidx]   <= hc_q[hidx] + IW'(1);
        hi_q         <= CW'(1);
        pos_q        <= '0;
        acc_q        <= '0;
        px_q         <= '0;
        py_q         <= '0;
      end else begin
        hc_q[hidx] <= '0;
        hi_q       <= hi_q + CW'(1);
      end
    end else if (cmd_i.scan && (j_q < robots)) begin
      if (rft_q[j_q[RW-1:0]] < bestf_q) begin
        bestf_q <= rft_q[j_q[RW-1:0]];
        pick_q  <= j_q[RW-1:0];
      end
      j_q <= j_q + JW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      tour_q   <= tour;
      start_q  <= bestf_q;
      finish_q <= finish;
      mko_q    <= (finish > mk_q) ? finish : mk_q;
      drop_q   <= ovf_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign tour_time_o     = tour_q;
  assign start_time_o    = start_q;
  assign end_time_o      = finish_q;
  assign makespan_o      = mko_q;
  assign cells_dropped_o = drop_q;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_CELLS)) else $error("cell count above capacity");
  a_commit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_valid_q) else $error("commit lost result");
  a_fin_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> finish_q >= start_q) else $error("finish before start");
  a_mk_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> mko_q >= finish_q) else $error("makespan low");
`endif

endmodule

[rtl/order_tour_list_scheduler.sv]
`timescale 1ns / 1ps
// Order tour list scheduler.
// Input channel in_s carries one pick cell per request (new_batch, cell_x,
// cell_y, last_cell). Requests are taken only while the block is idle; a
// request without last_cell is just stored. A request with last_cell
// closes the order and produces one result on out_s (tour_time, start_time,
// end_time, makespan, cells_dropped).
// Closing an order: every visiting order of the n stored cells is costed one
// leg per cycle (n legs and the return leg), followed by a compare step, with
// permutation steps between orders. Then the robot free times are scanned one
// robot per cycle (robot_count robots, at least one) and the result is
// registered in the commit state once the output register is free.
// Config writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) go to dock_time (index 0)
// and robot_count (index 1); the user writes only while idle (not enforced).
// Reset clears cell count, robot free times, makespan and the result valid
// flag; dock_time returns to 0 and robot_count to 1.
// If out_s stalls, the finished result holds in the output register and new
// cells are still taken; a second close waits until the first is taken.
module order_tour_list_scheduler
  import ots_pkg::*;
#(
  parameter int MAX_CELLS  = 5,
  parameter int MAX_ROBOTS = 8,
  parameter int COORD_BITS = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  ots_in_if.sink            in_s,
  ots_out_if.source         out_s
);

  cmd_t cmd;
  sts_t sts;

  ots_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_s.valid),
    .in_last_i  (in_s.last_cell),
    .in_ready_o (in_s.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ots_dp #(
    .MAX_CELLS  (MAX_CELLS),
    .MAX_ROBOTS (MAX_ROBOTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .new_batch_i     (in_s.new_batch),
    .cell_x_i        (in_s.cell_x),
    .cell_y_i        (in_s.cell_y),
    .out_ready_i     (out_s.ready),
    .out_valid_o     (out_s.valid),
    .tour_time_o     (out_s.tour_time),
    .start_time_o    (out_s.start_time),
    .end_time_o      (out_s.end_time),
    .makespan_o      (out_s.makespan),
    .cells_dropped_o (out_s.cells_dropped),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule
